// ===== rtl/owlsh_pkg.sv =====
// ----------------------------------------------------------------------------
// owlsh_pkg: shared definitions for the single-wire session host
// Holds the CRC-8 constants and helpers, the request codes, the reply
// classes and the result record that passes from the sequencer to the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

package owlsh_pkg;

	// CRC-8, polynomial x^8 + x^2 + x + 1, processed MSB first.
	localparam logic [7:0] CRC_SEED = 8'hAC;
	localparam logic [7:0] CRC_POLY = 8'h07;

	// Request codes understood by the partner.
	localparam logic [7:0] REQ_KEYS       = 8'h30;
	localparam logic [7:0] REQ_TOUCH      = 8'h40;
	localparam logic [7:0] REQ_PANEL_INFO = 8'h60;

	// Reply classes.
	localparam logic [1:0] CLS_KEY       = 2'd0;
	localparam logic [1:0] CLS_TOUCH     = 2'd1;
	localparam logic [1:0] CLS_INFO      = 2'd2;
	localparam logic [1:0] CLS_BACKLIGHT = 2'd3;

	// One result beat.
	typedef struct packed {
		logic       line_out;
		logic       line_drive;
		logic       busy_res;
		logic       done_res;
		logic       crc_ok;
		logic [1:0] reply_class;
		logic [7:0] reply_high;
		logic [7:0] reply_mid;
		logic [7:0] reply_low;
		logic [2:0] keys_changed;
	} res_t;

	// Advances the CRC by a single data bit.
	function automatic logic [7:0] crc8_bit(input logic [7:0] crc, input logic b);
		logic fb;
		fb = crc[7] ^ b;
		return {crc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
	endfunction

	// Advances the CRC by a whole byte, most significant bit first.
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] v);
		logic [7:0] c;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			c = crc8_bit(c, v[i]);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/owlsh_core.sv =====
// ----------------------------------------------------------------------------
// owlsh_core: session sequencer
// Holds the session state and works out, for one item, the next state and
// the result beat that reflects it. The state advances when step_en is high.
// The response CRC is accumulated one bit per slot as the bits arrive.
// ----------------------------------------------------------------------------
`default_nettype none

module owlsh_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step_en,
	input  wire logic             kind,
	input  wire logic [7:0]       request_byte,
	input  wire logic             line_in,
	output owlsh_pkg::res_t       res
);
	import owlsh_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_START    = 3'd1,
		PH_REQUEST  = 3'd2,
		PH_WAITING  = 3'd3,
		PH_RESPONSE = 3'd4,
		PH_STOPPING = 3'd5
	} phase_t;

	phase_t      phase_q, n_phase;
	logic [5:0]  slot_q, n_slot, slot_dec;
	logic [31:0] shift_q, n_shift, shift_new;
	logic [15:0] req_word_q, n_req_word;
	logic [7:0]  crc_q, n_crc;
	logic [7:0]  prev_keys_q, n_prev_keys;
	logic [7:0]  diff;

	// Next state and result for the item presented this cycle.
	always_comb begin
		n_phase     = phase_q;
		n_slot      = slot_q;
		n_shift     = shift_q;
		n_req_word  = req_word_q;
		n_crc       = crc_q;
		n_prev_keys = prev_keys_q;
		slot_dec    = slot_q - 6'd1;
		shift_new   = {shift_q[30:0], line_in};
		diff        = 8'h00;
		res         = '0;

		if (!kind) begin
			// A start is taken only while idle.
			if (phase_q == PH_IDLE) begin
				n_req_word = {request_byte, crc8_byte(CRC_SEED, request_byte)};
				n_slot     = 6'd1;
				n_phase    = PH_START;
			end
		end else if (phase_q != PH_IDLE) begin
			n_slot = slot_dec;
			unique case (phase_q)
				PH_START: begin
					if (slot_dec == 6'd0) begin
						n_slot  = 6'd16;
						n_phase = PH_REQUEST;
					end
				end
				PH_REQUEST: begin
					if (slot_dec == 6'd0) begin
						n_slot  = 6'd2;
						n_phase = PH_WAITING;
					end
				end
				PH_WAITING: begin
					if (slot_dec == 6'd0) begin
						n_slot  = 6'd32;
						n_shift = 32'h0;
						n_crc   = CRC_SEED;
						n_phase = PH_RESPONSE;
					end
				end
				PH_RESPONSE: begin
					n_shift = shift_new;
					// The first three bytes feed the CRC; the fourth is the check byte.
					if (slot_dec >= 6'd8) begin
						n_crc = crc8_bit(crc_q, line_in);
					end
					if (slot_dec == 6'd0) begin
						n_slot         = 6'd2;
						n_phase        = PH_STOPPING;
						res.done_res   = 1'b1;
						res.reply_high = shift_new[31:24];
						res.reply_mid  = shift_new[23:16];
						res.reply_low  = shift_new[15:8];
						res.crc_ok     = (crc_q == shift_new[7:0]);
						if (req_word_q[15:8] == REQ_KEYS) begin
							res.reply_class = CLS_KEY;
						end else if (req_word_q[15:8] == REQ_TOUCH) begin
							res.reply_class = CLS_TOUCH;
						end else if (req_word_q[15:8] == REQ_PANEL_INFO) begin
							res.reply_class = CLS_INFO;
						end else begin
							res.reply_class = CLS_BACKLIGHT;
						end
						// Key report: compare with the last accepted key byte.
						if (res.crc_ok && res.reply_class == CLS_KEY) begin
							diff             = prev_keys_q ^ shift_new[15:8];
							n_prev_keys      = shift_new[15:8];
							res.keys_changed = diff[2:0];
						end
					end
				end
				PH_STOPPING: begin
					if (slot_dec == 6'd0) begin
						n_phase = PH_IDLE;
					end
				end
				default: begin
					n_phase = PH_IDLE;
					n_slot  = 6'd0;
				end
			endcase
		end

		// Wire level after the item: driven high unless a slot says otherwise.
		res.line_out   = 1'b1;
		res.line_drive = 1'b1;
		unique case (n_phase)
			PH_START: begin
				res.line_out = 1'b0;
			end
			PH_REQUEST: begin
				res.line_out = (n_slot < 6'd16) ? n_req_word[n_slot[3:0]] : 1'b0;
			end
			PH_WAITING: begin
				if (n_slot >= 6'd2) begin
					res.line_out = n_req_word[0];
				end else begin
					res.line_drive = 1'b0;
				end
			end
			PH_RESPONSE: begin
				res.line_drive = 1'b0;
			end
			default: begin
			end
		endcase
		res.busy_res = (n_phase != PH_IDLE);
	end

	// Session state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			slot_q      <= 6'd0;
			shift_q     <= 32'h0;
			req_word_q  <= 16'h0;
			crc_q       <= 8'h00;
			prev_keys_q <= 8'h00;
		end else if (step_en) begin
			phase_q     <= n_phase;
			slot_q      <= n_slot;
			shift_q     <= n_shift;
			req_word_q  <= n_req_word;
			crc_q       <= n_crc;
			prev_keys_q <= n_prev_keys;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/one_wire_lcd_session_host.sv =====
// ----------------------------------------------------------------------------
// one_wire_lcd_session_host: host side of a single-wire request/response link
// Input register, session sequencer and result register on stream ports.
// ----------------------------------------------------------------------------
// Each beat on the slave port is either a session start (tuser 0) carrying
// the request byte, or a bit-period tick (tuser 1) carrying the sampled wire
// level, and each gives exactly one result beat with the wire drive and the
// session status after that item. The block takes one beat every clock while
// the result port does not stall. An accepted item sits in the input
// register while the sequencer's combinational slot update works out its
// result, which the result register takes when it is free or being emptied.
// A session runs one start slot, sixteen request bits, two turnaround slots,
// thirty-two response bits and two stop slots; the beat that takes the last
// response bit carries done, the CRC check, the reply class, the three reply
// bytes and, for good key replies, the changed keys.
// ----------------------------------------------------------------------------
`default_nettype none

module one_wire_lcd_session_host (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,  // request_byte[7:0], line_in[8], zero[15:9]
	input  wire logic        s_tuser,  // kind
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// line_out[0], line_drive[1], busy_res[2], done_res[3], crc_ok[4],
	// reply_class[6:5], reply_high[14:7], reply_mid[22:15], reply_low[30:23],
	// keys_changed[33:31], zero[39:34]
	output logic [39:0]      m_tdata
);
	import owlsh_pkg::*;

	logic       valid_s1;
	logic       kind_s1;
	logic [7:0] req_s1;
	logic       bit_s1;
	logic       adv;
	res_t       res_next;
	res_t       res_s2;

	// Stage one moves on whenever the result register is free or being emptied.
	assign adv      = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || adv;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_s1 <= s_tuser;
			req_s1  <= s_tdata[7:0];
			bit_s1  <= s_tdata[8];
		end
	end

	owlsh_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step_en      (adv),
		.kind         (kind_s1),
		.request_byte (req_s1),
		.line_in      (bit_s1),
		.res          (res_next)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (adv) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_next;
		end
	end

	assign m_tdata = {6'd0, res_s2.keys_changed, res_s2.reply_low, res_s2.reply_mid,
		res_s2.reply_high, res_s2.reply_class, res_s2.crc_ok, res_s2.done_res,
		res_s2.busy_res, res_s2.line_drive, res_s2.line_out};

`ifndef SYNTHESIS
	// A completed response always leaves the session in its stop slots.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res_s2.done_res |-> res_s2.busy_res)
		else $error("done result without an active session");

	// Changed keys are reported only on a good key reply.
	a_keys_class: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (res_s2.keys_changed != 3'd0) |->
			res_s2.done_res && res_s2.crc_ok && (res_s2.reply_class == CLS_KEY))
		else $error("keys_changed outside a good key reply");

	// A released line reads high.
	a_release_high: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !res_s2.line_drive |-> res_s2.line_out)
		else $error("released line not reported high");

	// An idle session drives the line high.
	a_idle_line: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !res_s2.busy_res |-> res_s2.line_drive && res_s2.line_out)
		else $error("idle session not driving the line high");

	// The input register never drops an item it holds while stalled.
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1)
		else $error("input register lost a stalled item");
`endif

endmodule

`default_nettype wire
